/* src/ines_header_parse_and_crc_macros.svh */
// Assertion macros for the iNES header parser.
`ifndef INES_HEADER_PARSE_AND_CRC_MACROS_SVH
`define INES_HEADER_PARSE_AND_CRC_MACROS_SVH

`ifndef NO_ASSERTIONS

`define INES_HP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define INES_HP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define INES_HP_ASSERT(lbl, clk, rstn, prop, msg)

`define INES_HP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/ines_hp_pkg.sv */
package ines_hp_pkg;

  localparam int unsigned PosW   = 23;
  localparam int unsigned TdataW = 64;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcSeed = 32'hFFFF_FFFF;

  localparam logic [7:0] MagicBytes [4] = '{8'h4E, 8'h45, 8'h53, 8'h1A};

  localparam logic [PosW-1:0] HeaderLastPos  = PosW'(15);
  localparam logic [PosW-1:0] TrainerLastPos = PosW'(511);

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StShortHeader = 3'd1,
    StBadMagic    = 3'd2,
    StNes2        = 3'd3,
    StShortRom    = 3'd4,
    StBadMapper   = 3'd5
  } status_e;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic        cpu_cycle_hook;
    logic        ppu_address_hook;
    logic [31:0] rom_crc;
    logic        trainer_present;
    logic [7:0]  chr_bank_count;
    logic [7:0]  prg_bank_count;
    logic [1:0]  mirror_mode;
    logic [7:0]  mapper_number;
    status_e     status;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic mapper_supported(input logic [7:0] m);
    return (m == 8'd0) || (m == 8'd1) || (m == 8'd2) || (m == 8'd3) || (m == 8'd4) ||
           (m == 8'd7) || (m == 8'd15) || (m == 8'd69) || (m == 8'd226);
  endfunction

endpackage

/* src/ines_hp_in_reg.sv */
module ines_hp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  ines_hp_pkg::in_t  s_item_i,
  output logic              valid_o,
  input  logic              take_i,
  output ines_hp_pkg::in_t  item_o
);

  logic             valid_q, valid_d;
  ines_hp_pkg::in_t item_q;
  logic             load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* src/ines_hp_parser.sv */
module ines_hp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ines_hp_pkg::in_t   in_item_i,
  output logic               take_o,
  input  logic               out_ready_i,
  output logic               res_valid_o,
  output ines_hp_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    PhHeader,
    PhTrainer,
    PhData,
    PhDrain
  } phase_e;

  typedef logic [ines_hp_pkg::PosW-1:0] pos_t;
  typedef logic [ines_hp_pkg::PosW:0]   pos_wide_t;

  phase_e              phase_q, phase_d;
  pos_t                pos_q, pos_d;
  pos_t                total_q, total_d;
  logic [31:0]         crc_q, crc_d;
  logic [7:0]          f6_q, f6_d;
  logic [7:0]          f7_q, f7_d;
  logic [7:0]          prg_q, prg_d;
  logic [7:0]          chr_q, chr_d;
  ines_hp_pkg::status_e err_q, err_d;

  pos_t                pos_inc;
  pos_wide_t           pos_inc_wide;
  logic                banks_any;
  logic                banks_any_d;
  logic                done;
  logic [7:0]          mapper;
  logic [7:0]          b;
  ines_hp_pkg::status_e status;
  logic                finish;

  assign b       = in_item_i.data;
  assign take_o  = in_valid_i && (!in_item_i.last || out_ready_i);
  assign finish  = take_o && in_item_i.last;
  assign res_valid_o = finish;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    total_d = total_q;
    crc_d   = crc_q;
    f6_d    = f6_q;
    f7_d    = f7_q;
    prg_d   = prg_q;
    chr_d   = chr_q;
    err_d   = err_q;

    pos_inc      = pos_q + pos_t'(1);
    pos_inc_wide = {1'b0, pos_q} + pos_wide_t'(1);
    banks_any    = (prg_q != 8'd0) || (chr_q != 8'd0);

    if (take_o) begin
      unique case (phase_q)
        PhHeader: begin
          if (pos_q < pos_t'(4)) begin
            if (b != ines_hp_pkg::MagicBytes[pos_q[1:0]]) begin
              err_d = ines_hp_pkg::StBadMagic;
            end
          end else if (pos_q == pos_t'(4)) begin
            prg_d = b;
          end else if (pos_q == pos_t'(5)) begin
            chr_d = b;
          end else if (pos_q == pos_t'(6)) begin
            f6_d = b;
          end else if (pos_q == pos_t'(7)) begin
            f7_d = b;
            if ((err_q == ines_hp_pkg::StOk) && ((b & 8'h0C) == 8'h08)) begin
              err_d = ines_hp_pkg::StNes2;
            end
          end
          if (pos_q >= ines_hp_pkg::HeaderLastPos) begin
            pos_d   = '0;
            total_d = pos_t'({prg_q, 14'd0}) + pos_t'({chr_q, 13'd0});
            if (err_d != ines_hp_pkg::StOk) begin
              phase_d = PhDrain;
            end else if (f6_q[2]) begin
              phase_d = PhTrainer;
            end else begin
              phase_d = banks_any ? PhData : PhDrain;
            end
          end else begin
            pos_d = pos_inc;
          end
        end
        PhTrainer: begin
          if (pos_q >= ines_hp_pkg::TrainerLastPos) begin
            pos_d   = '0;
            phase_d = banks_any ? PhData : PhDrain;
          end else begin
            pos_d = pos_inc;
          end
        end
        PhData: begin
          crc_d = ines_hp_pkg::crc_byte(crc_q, b);
          if (pos_inc_wide >= {1'b0, total_q}) begin
            pos_d   = '0;
            phase_d = PhDrain;
          end else begin
            pos_d = pos_inc;
          end
        end
        PhDrain: begin
        end
        default: begin
        end
      endcase
    end

    mapper      = {f7_d[7:4], f6_d[7:4]};
    banks_any_d = (prg_d != 8'd0) || (chr_d != 8'd0);
    done        = (phase_d == PhDrain) || ((phase_d == PhTrainer) && !banks_any_d);

    priority if (phase_d == PhHeader) begin
      status = ines_hp_pkg::StShortHeader;
    end else if (err_d != ines_hp_pkg::StOk) begin
      status = err_d;
    end else if (!done) begin
      status = ines_hp_pkg::StShortRom;
    end else if (!ines_hp_pkg::mapper_supported(mapper)) begin
      status = ines_hp_pkg::StBadMapper;
    end else begin
      status = ines_hp_pkg::StOk;
    end

    res_o        = '0;
    res_o.status = status;
    if ((status == ines_hp_pkg::StOk) || (status == ines_hp_pkg::StShortRom) ||
        (status == ines_hp_pkg::StBadMapper)) begin
      res_o.mapper_number    = mapper;
      res_o.mirror_mode      = f6_d[3] ? 2'd2 : {1'b0, f6_d[0]};
      res_o.prg_bank_count   = prg_d;
      res_o.chr_bank_count   = chr_d;
      res_o.trainer_present  = f6_d[2];
      res_o.rom_crc          = (status == ines_hp_pkg::StShortRom) ? 32'd0 : ~crc_d;
      res_o.ppu_address_hook = (mapper == 8'd4);
      res_o.cpu_cycle_hook   = (mapper == 8'd69);
    end

    if (finish) begin
      phase_d = PhHeader;
      pos_d   = '0;
      total_d = '0;
      crc_d   = ines_hp_pkg::CrcSeed;
      f6_d    = '0;
      f7_d    = '0;
      prg_d   = '0;
      chr_d   = '0;
      err_d   = ines_hp_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      total_q <= '0;
      crc_q   <= ines_hp_pkg::CrcSeed;
      f6_q    <= '0;
      f7_q    <= '0;
      prg_q   <= '0;
      chr_q   <= '0;
      err_q   <= ines_hp_pkg::StOk;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      crc_q   <= crc_d;
      f6_q    <= f6_d;
      f7_q    <= f7_d;
      prg_q   <= prg_d;
      chr_q   <= chr_d;
      err_q   <= err_d;
    end
  end

endmodule

/* src/ines_hp_out_reg.sv */
module ines_hp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  ines_hp_pkg::res_t  res_i,
  output logic               ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output ines_hp_pkg::res_t  m_res_o
);

  logic              valid_q, valid_d;
  ines_hp_pkg::res_t res_q;

  assign ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_res_o   = res_q;

endmodule

/* src/ines_header_parse_and_crc.sv */
// iNES ROM header parser with CRC-32 over the program and character data.
// The image enters one byte per transaction on the slave channel: tdata carries
// the byte and tlast marks the final byte of the image. Bytes are accepted at a
// sustained rate of one per cycle while the receiver keeps up, and an image may
// follow the previous one directly. Each byte lands in an input register before
// it is parsed, and the result for an image is registered in an output register
// once the parser has taken its last byte, which needs room in that register.
// The result is one 64-bit transaction holding status, mapper number,
// mirroring, bank counts, trainer flag, CRC and the two mapper hook flags.
// After the result the parser is back at the start of a header. Reset clears
// the valid flags of both channel registers and all parse state; no clearing
// pass is needed. When the receiver stalls, the result waits in the output
// register while bytes of the next image keep flowing; only the next last
// byte waits in the input register, which then holds off the sender.
`include "ines_header_parse_and_crc_macros.svh"

module ines_header_parse_and_crc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [10:3] mapper_number, [12:11] mirror_mode, [20:13] prg_bank_count,
  // [28:21] chr_bank_count, [29] trainer_present, [61:30] rom_crc,
  // [62] ppu_address_hook, [63] cpu_cycle_hook
  output logic [ines_hp_pkg::TdataW-1:0] m_axis_tdata_o
);

  ines_hp_pkg::in_t  s_item;
  ines_hp_pkg::in_t  in_item;
  ines_hp_pkg::res_t res;
  ines_hp_pkg::res_t m_res;
  logic              in_valid;
  logic              take;
  logic              out_ready;
  logic              res_valid;
  logic              out_hdr_err;
  logic              out_short_rom;

  assign s_item.data = s_axis_tdata_i;
  assign s_item.last = s_axis_tlast_i;

  ines_hp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .valid_o   (in_valid),
    .take_i    (take),
    .item_o    (in_item)
  );

  ines_hp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .take_o      (take),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ines_hp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata_o = {m_res.cpu_cycle_hook, m_res.ppu_address_hook, m_res.rom_crc,
                           m_res.trainer_present, m_res.chr_bank_count,
                           m_res.prg_bank_count, m_res.mirror_mode,
                           m_res.mapper_number, m_res.status};

  assign out_hdr_err = m_axis_tvalid_o &&
                       ((m_res.status == ines_hp_pkg::StShortHeader) ||
                        (m_res.status == ines_hp_pkg::StBadMagic) ||
                        (m_res.status == ines_hp_pkg::StNes2));
  assign out_short_rom = m_axis_tvalid_o && (m_res.status == ines_hp_pkg::StShortRom);

  `INES_HP_ASSERT_NEXT(a_res_reaches_port, clk_i, rst_ni, res_valid, m_axis_tvalid_o, "result lost")
  `INES_HP_ASSERT(a_stall_means_full, clk_i, rst_ni, s_axis_tready_o || in_valid, "empty but stalled")
  `INES_HP_ASSERT(a_take_needs_item, clk_i, rst_ni, !take || in_valid, "took an empty register")
  `INES_HP_ASSERT(a_header_error_clean, clk_i, rst_ni, !out_hdr_err || (m_axis_tdata_o[63:3] == 61'd0), "header error with fields")
  `INES_HP_ASSERT(a_short_rom_no_crc, clk_i, rst_ni, !out_short_rom || (m_res.rom_crc == 32'd0), "short image with CRC")

endmodule
